// File: hdl/ncm_pkg.sv
// Package for the normalisation cube map texel generator.
// Types and constants shared by the stage modules; no dependencies.
package ncm_pkg;

  localparam int unsigned CfgW    = 11;
  localparam int unsigned IdxW    = 10;
  localparam int unsigned CompW   = 13;   // signed component, |c| <= 2047+
  localparam int unsigned Len2W   = 24;   // sum of three squares
  localparam int unsigned InvW    = 17;   // floor(2^16/len), up to 2^16
  localparam int unsigned InvBits = 17;   // root digits, bit 16 down to 0
  localparam int unsigned FaceSizeReset = 64;

  typedef enum logic [2:0] {
    FacePosX = 3'd0,
    FaceNegX = 3'd1,
    FacePosY = 3'd2,
    FaceNegY = 3'd3,
    FacePosZ = 3'd4,
    FaceNegZ = 3'd5
  } face_e;

  typedef struct packed {
    logic                    zero;   // undefined face: all bytes zero
    logic signed [CompW-1:0] x;
    logic signed [CompW-1:0] y;
    logic signed [CompW-1:0] z;
  } dir_t;

  // one digit of the reciprocal root search travels with this word
  typedef struct packed {
    dir_t                dir;
    logic [Len2W-1:0]    len2;
    logic [InvW-1:0]     q;
  } root_t;

endpackage

// File: hdl/normalization_cube_map_texel.sv
// Top level of the normalisation cube map texel generator.
// Depends on ncm_pkg, ncm_dir, ncm_root and ncm_enc.
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+---------------------------
//  texel in | start, face_i, row_i, col_i    | start & !busy
//  config   | cfg_valid_i, cfg_data_i        | cfg_valid_i & cfg_ready_o
//  result   | done_o, red_o, green_o, blue_o | done_o, one cycle
//
// One word enters every cycle; busy is never raised. Each word passes the
// direction and squares registers, one root unit per reciprocal root digit
// (one multiplier pair each) and the encode registers. Reset clears the valid
// bits and sets face_size to 64. The receiver cannot stall, so nothing holds.
module normalization_cube_map_texel import ncm_pkg::*; #(
  parameter int unsigned MAX_FACE_SIZE = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic [2:0]      face_i,
  input  logic [IdxW-1:0] row_i,
  input  logic [IdxW-1:0] col_i,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CfgW-1:0] cfg_data_i,
  output logic            done_o,
  output logic [7:0]      red_o,
  output logic [7:0]      green_o,
  output logic [7:0]      blue_o
);
  logic [CfgW-1:0] size_d, size_q;
  logic            dvld;
  dir_t            dir;
  logic [Len2W-1:0] len2;
  logic  rvld [InvBits+1];
  root_t rwd  [InvBits+1];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // writes above the maximum saturate; compared at full width
  assign size_d = (32'(cfg_data_i) > MAX_FACE_SIZE) ? CfgW'(MAX_FACE_SIZE) : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= CfgW'(FaceSizeReset);
    end else if (cfg_valid_i && cfg_ready_o) begin
      size_q <= size_d;
    end
  end

  ncm_dir u_dir (
    .clk_i, .rst_ni,
    .vld_i (start && !busy),
    .face_i, .row_i, .col_i,
    .size_i (size_q),
    .vld_o (dvld),
    .dir_o (dir),
    .len2_o(len2)
  );

  assign rvld[0]     = dvld;
  assign rwd[0].dir  = dir;
  assign rwd[0].len2 = len2;
  assign rwd[0].q    = '0;

  // digits from the top bit down, one unit each
  for (genvar g = 0; g < InvBits; g++) begin : g_root
    ncm_root #(.Bit(InvBits - 1 - g)) u_root (
      .clk_i, .rst_ni,
      .vld_i (rvld[g]),
      .wd_i  (rwd[g]),
      .vld_o (rvld[g+1]),
      .wd_o  (rwd[g+1])
    );
  end

  ncm_enc u_enc (
    .clk_i, .rst_ni,
    .vld_i  (rvld[InvBits]),
    .wd_i   (rwd[InvBits]),
    .vld_o  (done_o),
    .red_o, .green_o, .blue_o
  );
endmodule

// File: hdl/ncm_dir.sv
// Direction stage: face, row and column to signed doubled coordinates.
// Depends on ncm_pkg.
module ncm_dir import ncm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  logic [2:0]      face_i,
  input  logic [IdxW-1:0] row_i,
  input  logic [IdxW-1:0] col_i,
  input  logic [CfgW-1:0] size_i,
  output logic            vld_o,
  output dir_t            dir_o,
  output logic [Len2W-1:0] len2_o
);
  logic signed [CompW-1:0] s, a, b;
  dir_t dir_d, dir_q;
  logic vld_q, vld2_q;
  dir_t dir2_q;
  logic [Len2W-1:0] len2_q;
  logic signed [2*CompW-1:0] sx, sy, sz;

  always_comb begin
    s = CompW'(signed'({1'b0, size_i}));
    a = CompW'(signed'({2'b0, row_i, 1'b1})) - s;
    b = CompW'(signed'({2'b0, col_i, 1'b1})) - s;
    dir_d = '0;
    case (face_i)
      FacePosX: begin dir_d.x = s;  dir_d.y = -a; dir_d.z = -b; end
      FaceNegX: begin dir_d.x = -s; dir_d.y = -a; dir_d.z = b;  end
      FacePosY: begin dir_d.x = b;  dir_d.y = s;  dir_d.z = a;  end
      FaceNegY: begin dir_d.x = b;  dir_d.y = -s; dir_d.z = -a; end
      FacePosZ: begin dir_d.x = b;  dir_d.y = -a; dir_d.z = s;  end
      FaceNegZ: begin dir_d.x = -b; dir_d.y = -a; dir_d.z = -s; end
      default:  begin dir_d.zero = 1'b1; dir_d.x = 13'sd1; end
    endcase
    sx = dir_q.x * dir_q.x;
    sy = dir_q.y * dir_q.y;
    sz = dir_q.z * dir_q.z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld_q  <= vld_i;
      vld2_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dir_q  <= dir_d;
    dir2_q <= dir_q;
    len2_q <= Len2W'(sx) + Len2W'(sy) + Len2W'(sz);
  end

  assign vld_o  = vld2_q;
  assign dir_o  = dir2_q;
  assign len2_o = len2_q;
endmodule

// File: hdl/ncm_root.sv
// One digit of the reciprocal square root search: keep bit k of q when
// q*q*len2 <= 2^32. Two registers deep. Depends on ncm_pkg.
module ncm_root import ncm_pkg::*; #(
  parameter int unsigned Bit = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  vld_i,
  input  root_t wd_i,
  output logic  vld_o,
  output root_t wd_o
);
  logic [InvW-1:0]   t;
  logic [2*InvW-1:0] tt_d, tt_q;
  logic [2*InvW+Len2W-1:0] prod;
  root_t wd_q, wd2_d, wd2_q;
  logic vld_q, vld2_q;

  always_comb begin
    t    = wd_i.q | (InvW'(1) << Bit);
    tt_d = 34'(t) * 34'(t);
    prod = (2*InvW+Len2W)'(tt_q) * (2*InvW+Len2W)'(wd_q.len2);
    wd2_d = wd_q;
    if (prod <= (2*InvW+Len2W)'(64'h1_0000_0000)) begin
      wd2_d.q = wd_q.q | (InvW'(1) << Bit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld_q  <= vld_i;
      vld2_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tt_q  <= tt_d;
    wd_q  <= wd_i;
    wd2_q <= wd2_d;
  end

  assign vld_o = vld2_q;
  assign wd_o  = wd2_q;
endmodule

// File: hdl/ncm_enc.sv
// Encode stage: c*inv, offset, scale by 255, keep bits 24:17.
// Depends on ncm_pkg.
module ncm_enc import ncm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       vld_i,
  input  root_t      wd_i,
  output logic       vld_o,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o
);
  localparam int unsigned NW = CompW + InvW + 1;
  logic signed [NW-1:0] n_d [3];
  logic signed [NW-1:0] n_q [3];
  logic signed [CompW-1:0] c [3];
  logic [NW+7:0] u [3];
  logic [7:0] byt [3];
  logic zero_q, vld_q, vld2_q;
  logic [7:0] byt_q [3];

  always_comb begin
    c[0] = wd_i.dir.x;
    c[1] = wd_i.dir.y;
    c[2] = wd_i.dir.z;
    for (int i = 0; i < 3; i++) begin
      n_d[i] = NW'(c[i]) * signed'({1'b0, (NW-1)'(wd_i.q)}) + NW'(65536);
      u[i]   = (NW+8)'(unsigned'(n_q[i])) * (NW+8)'(255);
      byt[i] = u[i][24:17];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld_q  <= vld_i;
      vld2_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    zero_q  <= wd_i.dir.zero;
    for (int i = 0; i < 3; i++) begin
      byt_q[i] <= zero_q ? 8'd0 : byt[i];
    end
  end

  assign vld_o   = vld2_q;
  assign red_o   = byt_q[0];
  assign green_o = byt_q[1];
  assign blue_o  = byt_q[2];
endmodule
